// ===== design/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types for the beep pattern sequencer: request codes and the request
// and result items passed between the pipeline stages.
// ----------------------------------------------------------------------------
package bps_pkg;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_PLAY   = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_MUTE   = 2'd3
  } req_code_t;

  typedef struct packed {
    req_code_t   req_type;
    logic [31:0] now_ms;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [15:0] repeat_count;
    logic        mute_value;
  } req_item_t;

  typedef struct packed {
    logic drive;
    logic play_accepted;
    logic busy_res;
    logic is_muted;
  } res_item_t;

endpackage

// ===== design/bps_req_stage.sv =====
// ----------------------------------------------------------------------------
// bps_req_stage
// Input register: captures one request item and holds it while the
// sequencer core cannot move it on.
// ----------------------------------------------------------------------------
module bps_req_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bps_pkg::req_item_t req_in,
  output logic              held_valid,
  output bps_pkg::req_item_t held_item,
  input  logic              down_stall
);
  import bps_pkg::*;

  assign req_stall = held_valid && down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      held_item <= req_in;
    end
  end

endmodule

// ===== design/bps_core.sv =====
// ----------------------------------------------------------------------------
// bps_core
// Pattern state and the single-pass step logic: applies one request item to
// the state and forms its result item.
// ----------------------------------------------------------------------------
module bps_core #(
  parameter int unsigned MAX_PHASE_MS = 60000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  bps_pkg::req_item_t item,
  input  logic               res_stall,
  output logic               fire,
  output bps_pkg::res_item_t res
);
  import bps_pkg::*;

  localparam logic [15:0] MaxPhase = 16'(MAX_PHASE_MS);

  logic        running, running_next;
  logic        sounding, sounding_next;
  logic        mute_flag, mute_flag_next;
  logic [15:0] beeps_left, beeps_left_next;
  logic [31:0] phase_deadline, phase_deadline_next;
  logic [15:0] stored_on_time, stored_on_time_next;
  logic [15:0] stored_off_time, stored_off_time_next;

  logic [31:0] diff;
  logic        passed;
  logic        play_ok;

  assign fire    = item_valid && !res_stall;
  assign diff    = item.now_ms - phase_deadline;
  assign passed  = !diff[31];
  assign play_ok = !mute_flag && (item.repeat_count != 16'd0) && (item.on_time_ms != 16'd0)
                   && (item.on_time_ms <= MaxPhase) && (item.off_time_ms <= MaxPhase);

  always_comb begin
    running_next         = running;
    sounding_next        = sounding;
    mute_flag_next       = mute_flag;
    beeps_left_next      = beeps_left;
    phase_deadline_next  = phase_deadline;
    stored_on_time_next  = stored_on_time;
    stored_off_time_next = stored_off_time;
    case (item.req_type)
      REQ_UPDATE: begin
        if (running && passed) begin
          if (sounding) begin
            sounding_next   = 1'b0;
            beeps_left_next = beeps_left - 16'd1;
            if (beeps_left == 16'd1) begin
              running_next = 1'b0;
            end else begin
              phase_deadline_next = item.now_ms + {16'd0, stored_off_time};
            end
          end else begin
            sounding_next       = 1'b1;
            phase_deadline_next = item.now_ms + {16'd0, stored_on_time};
          end
        end
      end
      REQ_PLAY: begin
        if (play_ok) begin
          stored_on_time_next  = item.on_time_ms;
          stored_off_time_next = item.off_time_ms;
          beeps_left_next      = item.repeat_count;
          running_next         = 1'b1;
          sounding_next        = 1'b1;
          phase_deadline_next  = item.now_ms + {16'd0, item.on_time_ms};
        end
      end
      REQ_CANCEL: begin
        running_next    = 1'b0;
        sounding_next   = 1'b0;
        beeps_left_next = 16'd0;
      end
      default: begin
        mute_flag_next = item.mute_value;
        if (item.mute_value) begin
          running_next    = 1'b0;
          sounding_next   = 1'b0;
          beeps_left_next = 16'd0;
        end
      end
    endcase
  end

  always_comb begin
    res.drive         = sounding_next;
    res.play_accepted = (item.req_type == REQ_PLAY) && play_ok;
    res.busy_res      = running_next;
    res.is_muted      = mute_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      sounding        <= 1'b0;
      mute_flag       <= 1'b0;
      beeps_left      <= 16'd0;
      phase_deadline  <= 32'd0;
      stored_on_time  <= 16'd0;
      stored_off_time <= 16'd0;
    end else if (fire) begin
      running         <= running_next;
      sounding        <= sounding_next;
      mute_flag       <= mute_flag_next;
      beeps_left      <= beeps_left_next;
      phase_deadline  <= phase_deadline_next;
      stored_on_time  <= stored_on_time_next;
      stored_off_time <= stored_off_time_next;
    end
  end

endmodule

// ===== design/bps_res_stage.sv =====
// ----------------------------------------------------------------------------
// bps_res_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module bps_res_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  input  bps_pkg::res_item_t up_item,
  output logic               up_stall,
  output logic               res_valid,
  input  logic               res_stall,
  output bps_pkg::res_item_t res_item
);
  import bps_pkg::*;

  assign up_stall = res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!up_stall) begin
      res_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      res_item <= up_item;
    end
  end

endmodule

// ===== design/beep_pattern_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_unit
// Buzzer on/off pattern sequencer driven by request items.
//
// Request channel (req_valid / req_stall) carries one request item: update
// tick, play, cancel or set mute, with a wrapping millisecond timestamp.
// Result channel (res_valid / res_stall) returns exactly one result item per
// request: drive level, play acceptance, busy and mute flags.
// From acceptance to res_valid the item passes the input register, then the
// step logic and pattern state ahead of the result register.
// Throughput: one item per cycle while the receiver does not stall; the pattern
// state updates in the same cycle the item leaves the input register.
// Reset (rst, synchronous): pipeline empties, buzzer off, no pattern, unmuted.
// When the receiver stalls, the result register holds its item, the input
// register fills, and req_stall rises after that until the result is taken.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer_unit #(
  parameter int unsigned MAX_PHASE_MS = 60000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [15:0] on_time_ms,
  input  logic [15:0] off_time_ms,
  input  logic [15:0] repeat_count,
  input  logic        mute_value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        drive,
  output logic        play_accepted,
  output logic        busy_res,
  output logic        is_muted
);
  import bps_pkg::*;

  req_item_t req_in;
  req_item_t held_item;
  logic      held_valid;
  logic      core_stall;
  logic      fire;
  res_item_t core_res;
  res_item_t res_item;

  always_comb begin
    req_in.req_type     = req_code_t'(req_type);
    req_in.now_ms       = now_ms;
    req_in.on_time_ms   = on_time_ms;
    req_in.off_time_ms  = off_time_ms;
    req_in.repeat_count = repeat_count;
    req_in.mute_value   = mute_value;
  end

  bps_req_stage u_req_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_in     (req_in),
    .held_valid (held_valid),
    .held_item  (held_item),
    .down_stall (core_stall)
  );

  bps_core #(
    .MAX_PHASE_MS (MAX_PHASE_MS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held_valid),
    .item       (held_item),
    .res_stall  (core_stall),
    .fire       (fire),
    .res        (core_res)
  );

  bps_res_stage u_res_stage (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (held_valid),
    .up_item   (core_res),
    .up_stall  (core_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  assign drive         = res_item.drive;
  assign play_accepted = res_item.play_accepted;
  assign busy_res      = res_item.busy_res;
  assign is_muted      = res_item.is_muted;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> held_valid)
    else $error("accepted request item not held in input register");

  a_fire_delivers: assert property (@(posedge clk) disable iff (rst)
    fire |=> res_valid)
    else $error("processed item did not reach result register");

  a_play_sounds: assert property (@(posedge clk) disable iff (rst)
    res_valid && play_accepted |-> drive && busy_res && !is_muted)
    else $error("accepted play without sounding pattern");

  a_mute_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && (is_muted || !busy_res) |-> !(is_muted && busy_res) && !(drive && !busy_res))
    else $error("pattern running while muted or sounding while idle");

endmodule
